### hw/rtl/prst_pkg.sv
// Shared widths, constants, types and tables of the polygon rotate/scale/translate block.
package prst_pkg;

   localparam int DEF_NUM_VERTICES  = 7;
   localparam int DEF_CORDIC_STAGES = 16;
   localparam int MAX_STAGES        = 24;
   localparam int OUTLINE_SIZE      = 7;

   localparam int ANG_W      = 16;
   localparam int SCL_W      = 16;
   localparam int POS_W      = 16;
   localparam int OUT_W      = 19;
   localparam int IDX_OUT_W  = 3;
   localparam int SC_W       = 19;
   localparam int Z_W        = 32;
   localparam int T_W        = 24;
   localparam int PROD_W     = T_W + SCL_W + 1;
   localparam int FRAC_SHIFT = 20;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_ANGLE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR   = 8'd1;

   localparam logic signed [ANG_W-1:0] ANGLE_RESET   = 16'sd0;
   localparam logic [SCL_W-1:0]        SCALE_RESET   = 16'd256;
   localparam logic signed [ANG_W:0]   QUARTER_TURN  = 17'sd16384;
   localparam logic signed [ANG_W:0]   HALF_TURN     = 17'sd32768;
   localparam logic signed [SC_W-1:0]  INV_GAIN      = 19'sd39797;

   typedef enum logic [1:0] {
      COORD_ZERO,
      COORD_POS,
      COORD_NEG
   } coord_type;

   typedef struct packed {
      logic signed [SC_W-1:0]  x;
      logic signed [SC_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
      logic                    flip;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
   } cordic_data_type;

   // atan(2^-i), 2^32 per full turn
   function automatic logic [Z_W-1:0] atan_step(input int stage);
      logic [Z_W-1:0] r;
      case (stage)
         0:       r = 32'd536870912;
         1:       r = 32'd316933406;
         2:       r = 32'd167458907;
         3:       r = 32'd85004756;
         4:       r = 32'd42667331;
         5:       r = 32'd21354465;
         6:       r = 32'd10679838;
         7:       r = 32'd5340245;
         8:       r = 32'd2670163;
         9:       r = 32'd1335087;
         10:      r = 32'd667544;
         11:      r = 32'd333772;
         12:      r = 32'd166886;
         13:      r = 32'd83443;
         14:      r = 32'd41722;
         15:      r = 32'd20861;
         16:      r = 32'd10430;
         17:      r = 32'd5215;
         18:      r = 32'd2608;
         19:      r = 32'd1304;
         20:      r = 32'd652;
         21:      r = 32'd326;
         22:      r = 32'd163;
         23:      r = 32'd81;
         default: r = '0;
      endcase
      return r;
   endfunction

   // outline x in units of 30
   function automatic coord_type outline_x(input logic [2:0] v);
      coord_type c;
      case (v)
         3'd1:    c = COORD_POS;
         3'd3:    c = COORD_NEG;
         3'd4:    c = COORD_NEG;
         3'd6:    c = COORD_POS;
         default: c = COORD_ZERO;
      endcase
      return c;
   endfunction

   // outline y in units of 30
   function automatic coord_type outline_y(input logic [2:0] v);
      coord_type c;
      case (v)
         3'd2:    c = COORD_NEG;
         3'd3:    c = COORD_NEG;
         3'd4:    c = COORD_POS;
         3'd5:    c = COORD_POS;
         default: c = COORD_ZERO;
      endcase
      return c;
   endfunction

   function automatic logic signed [T_W-1:0] coord_sel(input coord_type c,
                                                      input logic signed [T_W-1:0] v);
      logic signed [T_W-1:0] r;
      case (c)
         COORD_POS: r = v;
         COORD_NEG: r = -v;
         default:   r = '0;
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/prst_if.sv
// Handshake channel interfaces: position input, vertex result and register write.
interface prst_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [prst_pkg::POS_W-1:0] pos_x;
   logic signed [prst_pkg::POS_W-1:0] pos_y;
   modport source (output valid, pos_x, pos_y, input ready);
   modport sink (input valid, pos_x, pos_y, output ready);
endinterface

interface prst_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [prst_pkg::IDX_OUT_W-1:0]        vertex_index;
   logic signed [prst_pkg::OUT_W-1:0]     global_x;
   logic signed [prst_pkg::OUT_W-1:0]     global_y;
   logic                                  last_vertex;
   modport source (output valid, vertex_index, global_x, global_y, last_vertex,
                   input ready);
   modport sink (input valid, vertex_index, global_x, global_y, last_vertex,
                 output ready);
endinterface

interface prst_csr_if;
   logic                              valid;
   logic                              ready;
   logic [prst_pkg::CSR_IDX_W-1:0]    index;
   logic [prst_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/prst_cordic_cell.sv
// One CORDIC rotation cell of the sine/cosine chain, with its own handshake register.
module prst_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  prst_pkg::cordic_data_type in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output prst_pkg::cordic_data_type out_data
);

   logic                      valid_ff, valid_in;
   prst_pkg::cordic_data_type data_ff, data_in;
   logic signed [prst_pkg::SC_W-1:0] x_sh, y_sh;
   logic signed [prst_pkg::Z_W-1:0]  atan_v;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign x_sh   = in_data.x >>> STAGE;
   assign y_sh   = in_data.y >>> STAGE;
   assign atan_v = $signed(prst_pkg::atan_step(STAGE));

   always_comb begin
      data_in = in_data;
      if (!in_data.z[prst_pkg::Z_W-1]) begin
         data_in.x = in_data.x - y_sh;
         data_in.y = in_data.y + x_sh;
         data_in.z = in_data.z - atan_v;
      end else begin
         data_in.x = in_data.x + y_sh;
         data_in.y = in_data.y - x_sh;
         data_in.z = in_data.z + atan_v;
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### hw/rtl/prst_vertex_unit.sv
// Vertex sequencer and rotate/scale/round/translate pipeline with the result register.
module prst_vertex_unit #(
   parameter int NUM_VERTICES = prst_pkg::DEF_NUM_VERTICES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  prst_pkg::cordic_data_type   in_data,
   input  logic [prst_pkg::SCL_W-1:0]  scale,
   prst_rsp_if.source                  rsp_ch
);

   localparam int IDX_W = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_VERTICES - 1);
   localparam logic [2:0] TAB_LAST = 3'(prst_pkg::OUTLINE_SIZE - 1);
   localparam logic signed [prst_pkg::PROD_W-1:0] RND_HALF =
      prst_pkg::PROD_W'(1) << (prst_pkg::FRAC_SHIFT - 1);

   logic adv, free, load, issue, last_issue;

   // sequencer
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]       tab_ff, tab_in;
   logic signed [prst_pkg::T_W-1:0]   c30_ff, c30_in, s30_ff, s30_in;
   logic signed [prst_pkg::POS_W-1:0] px_ff, py_ff;
   logic signed [prst_pkg::T_W-1:0]   cos_ext, sin_ext;

   // stage A: rotated outline vertex (unscaled)
   logic                              a_valid_ff;
   logic signed [prst_pkg::T_W-1:0]   a_tx_ff, a_tx_in, a_ty_ff, a_ty_in;
   logic [prst_pkg::IDX_OUT_W-1:0]    a_idx_ff;
   logic                              a_last_ff;
   logic signed [prst_pkg::POS_W-1:0] a_px_ff, a_py_ff;

   // stage B: scaled
   logic                              b_valid_ff;
   logic signed [prst_pkg::PROD_W-1:0] b_rx_ff, b_rx_in, b_ry_ff, b_ry_in;
   logic signed [prst_pkg::SCL_W:0]   scl_s;
   logic [prst_pkg::IDX_OUT_W-1:0]    b_idx_ff;
   logic                              b_last_ff;
   logic signed [prst_pkg::POS_W-1:0] b_px_ff, b_py_ff;

   // output register
   logic                              out_valid_ff;
   logic signed [prst_pkg::PROD_W-1:0] rx_sh, ry_sh;
   logic signed [prst_pkg::OUT_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [prst_pkg::IDX_OUT_W-1:0]    out_idx_ff;
   logic                              out_last_ff;

   assign adv        = !out_valid_ff || rsp_ch.ready;
   assign last_issue = busy_ff && (idx_ff == IDX_LAST);
   assign free       = !busy_ff || last_issue;
   assign in_ready   = adv && free;
   assign load       = in_ready && in_valid;
   assign issue      = adv && busy_ff;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      tab_in  = tab_ff;
      if (issue) begin
         if (last_issue) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
         tab_in = (tab_ff == TAB_LAST) ? 3'd0 : tab_ff + 3'd1;
      end
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         tab_in  = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         tab_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         tab_ff  <= tab_in;
      end
   end

   // fold correction, then 30*cos and 30*sin by shift and subtract
   assign cos_ext = in_data.flip ? -prst_pkg::T_W'(in_data.x) : prst_pkg::T_W'(in_data.x);
   assign sin_ext = in_data.flip ? -prst_pkg::T_W'(in_data.y) : prst_pkg::T_W'(in_data.y);
   assign c30_in  = (cos_ext <<< 5) - (cos_ext <<< 1);
   assign s30_in  = (sin_ext <<< 5) - (sin_ext <<< 1);

   always_ff @(posedge clock) begin
      if (load) begin
         c30_ff <= c30_in;
         s30_ff <= s30_in;
         px_ff  <= in_data.pos_x;
         py_ff  <= in_data.pos_y;
      end
   end

   assign a_tx_in = prst_pkg::coord_sel(prst_pkg::outline_x(tab_ff), c30_ff)
                  - prst_pkg::coord_sel(prst_pkg::outline_y(tab_ff), s30_ff);
   assign a_ty_in = prst_pkg::coord_sel(prst_pkg::outline_x(tab_ff), s30_ff)
                  + prst_pkg::coord_sel(prst_pkg::outline_y(tab_ff), c30_ff);

   assign scl_s   = $signed({1'b0, scale});
   assign b_rx_in = a_tx_ff * scl_s;
   assign b_ry_in = a_ty_ff * scl_s;

   assign rx_sh = (b_rx_ff + RND_HALF) >>> prst_pkg::FRAC_SHIFT;
   assign ry_sh = (b_ry_ff + RND_HALF) >>> prst_pkg::FRAC_SHIFT;
   assign gx_in = rx_sh[prst_pkg::OUT_W-1:0] + prst_pkg::OUT_W'(b_px_ff);
   assign gy_in = ry_sh[prst_pkg::OUT_W-1:0] + prst_pkg::OUT_W'(b_py_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= busy_ff;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_tx_ff     <= a_tx_in;
         a_ty_ff     <= a_ty_in;
         a_idx_ff    <= prst_pkg::IDX_OUT_W'(idx_ff);
         a_last_ff   <= last_issue;
         a_px_ff     <= px_ff;
         a_py_ff     <= py_ff;
         b_rx_ff     <= b_rx_in;
         b_ry_ff     <= b_ry_in;
         b_idx_ff    <= a_idx_ff;
         b_last_ff   <= a_last_ff;
         b_px_ff     <= a_px_ff;
         b_py_ff     <= a_py_ff;
         gx_ff       <= gx_in;
         gy_ff       <= gy_in;
         out_idx_ff  <= b_idx_ff;
         out_last_ff <= b_last_ff;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.vertex_index = out_idx_ff;
   assign rsp_ch.global_x     = gx_ff;
   assign rsp_ch.global_y     = gy_ff;
   assign rsp_ch.last_vertex  = out_last_ff;

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_idx_ff == prst_pkg::IDX_OUT_W'(IDX_LAST)))
      else $error("last flag on a vertex other than the final one");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= IDX_LAST))
      else $error("vertex counter out of range");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && (idx_ff == '0) && (tab_ff == 3'd0)))
      else $error("new position not started at the first vertex");

   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      (adv && !busy_ff) |=> !a_valid_ff)
      else $error("vertex issued while sequencer idle");

endmodule

### hw/rtl/polygon_rotate_scale_translate.sv
// Top level: register file, angle fold, CORDIC cell chain and vertex unit.
//
// Usage: each item on req_ch carries a reference position (pos_x, pos_y, Q12.4).
// For it the block returns NUM_VERTICES items on rsp_ch, one per outline vertex in
// order, each the vertex scaled by scale_factor (Q8.8), rotated by rotation_angle
// (binary angle) and offset by the position, in Q15.4; the final one has
// last_vertex set. csr_ch writes rotation_angle (index 0) and scale_factor
// (index 1); it is always ready, other indexes are ignored. Write registers only
// while no item is in flight.
// Datapath: an item passes the chain of min(CORDIC_STAGES,24) CORDIC cells,
// then the vertex load, rotate, scale and output registers.
// Throughput: one vertex per cycle while rsp_ch does not stall, set by the vertex
// sequencer, which takes a new item as it issues the last vertex of the previous
// one; later items queue in the CORDIC cells meanwhile.
// Reset clears all valid state and sets angle 0 and scale 1.0.
// When rsp_ch stalls, the output register holds and the pipeline, sequencer and
// chain back up behind it; req_ch.ready drops once the chain is full.
module polygon_rotate_scale_translate #(
   parameter int NUM_VERTICES  = prst_pkg::DEF_NUM_VERTICES,
   parameter int CORDIC_STAGES = prst_pkg::DEF_CORDIC_STAGES
) (
   input  logic       clock,
   input  logic       reset,
   prst_req_if.sink   req_ch,
   prst_rsp_if.source rsp_ch,
   prst_csr_if.sink   csr_ch
);

   localparam int NUM_CELLS = (CORDIC_STAGES > prst_pkg::MAX_STAGES) ?
                              prst_pkg::MAX_STAGES : CORDIC_STAGES;

   logic signed [prst_pkg::ANG_W-1:0] angle_ff, angle_in;
   logic [prst_pkg::SCL_W-1:0]        scale_ff, scale_in;

   logic signed [prst_pkg::ANG_W:0]   ang_ext, ang_fold;
   logic                              fold_hi, fold_lo;

   prst_pkg::cordic_data_type chain_data  [NUM_CELLS+1];
   logic                      chain_valid [NUM_CELLS+1];
   logic                      chain_ready [NUM_CELLS+1];

   assign csr_ch.ready = 1'b1;

   always_comb begin
      angle_in = angle_ff;
      scale_in = scale_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            prst_pkg::CSR_ROTATION_ANGLE: angle_in = $signed(csr_ch.data);
            prst_pkg::CSR_SCALE_FACTOR:   scale_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= prst_pkg::ANGLE_RESET;
         scale_ff <= prst_pkg::SCALE_RESET;
      end else begin
         angle_ff <= angle_in;
         scale_ff <= scale_in;
      end
   end

   // fold into [-pi/2, pi/2]; the sign flip is applied after the chain
   assign ang_ext  = {angle_ff[prst_pkg::ANG_W-1], angle_ff};
   assign fold_hi  = ang_ext > prst_pkg::QUARTER_TURN;
   assign fold_lo  = ang_ext < -prst_pkg::QUARTER_TURN;
   assign ang_fold = fold_hi ? ang_ext - prst_pkg::HALF_TURN :
                     fold_lo ? ang_ext + prst_pkg::HALF_TURN : ang_ext;

   always_comb begin
      chain_data[0].x     = prst_pkg::INV_GAIN;
      chain_data[0].y     = '0;
      chain_data[0].z     = $signed({ang_fold[prst_pkg::ANG_W-1:0], 16'b0});
      chain_data[0].flip  = fold_hi || fold_lo;
      chain_data[0].pos_x = req_ch.pos_x;
      chain_data[0].pos_y = req_ch.pos_y;
   end

   assign chain_valid[0] = req_ch.valid;
   assign req_ch.ready   = chain_ready[0];

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      prst_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   prst_vertex_unit #(
      .NUM_VERTICES (NUM_VERTICES)
   ) u_vertex (
      .clock    (clock),
      .reset    (reset),
      .in_valid (chain_valid[NUM_CELLS]),
      .in_ready (chain_ready[NUM_CELLS]),
      .in_data  (chain_data[NUM_CELLS]),
      .scale    (scale_ff),
      .rsp_ch   (rsp_ch)
   );

endmodule

### tb/polygon_rotate_scale_translate_tb.sv
// Self-checking testbench for polygon_rotate_scale_translate: positions in, transformed outline out.
module polygon_rotate_scale_translate_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAGES      = (prst_pkg::DEF_CORDIC_STAGES > prst_pkg::MAX_STAGES) ?
                                prst_pkg::MAX_STAGES : prst_pkg::DEF_CORDIC_STAGES;
   localparam int LATENCY     = STAGES + 3;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_PRINTED = 50;
   localparam logic [prst_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 8'hA5;

   typedef struct packed {
      logic signed [prst_pkg::POS_W-1:0] x;
      logic signed [prst_pkg::POS_W-1:0] y;
   } position_type;

   typedef struct packed {
      logic [prst_pkg::IDX_OUT_W-1:0]    index;
      logic signed [prst_pkg::OUT_W-1:0] gx;
      logic signed [prst_pkg::OUT_W-1:0] gy;
      logic                              last;
   } vertex_type;

   logic clock = 1'b0;
   logic reset;

   prst_req_if req_ch ();
   prst_rsp_if rsp_ch ();
   prst_csr_if csr_ch ();

   polygon_rotate_scale_translate u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   position_type                      positions_pending[$];
   vertex_type                        vertices_due[$];
   logic signed [prst_pkg::ANG_W-1:0] angle_now = prst_pkg::ANGLE_RESET;
   logic [prst_pkg::SCL_W-1:0]        scale_now = prst_pkg::SCALE_RESET;
   int                                mismatches = 0;
   bit                                calm = 1'b0;
   int                                hold_asked = 0;
   int                                hold_seen;
   int                                hold_left;
   int                                stall_left;
   int                                gap_left;
   position_type                      next_pos;
   vertex_type                        got_vertex;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      if (mismatches < MAX_PRINTED)
         $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic longint atan_turn(input int i);
      case (i)
         0:  return 536870912;
         1:  return 316933406;
         2:  return 167458907;
         3:  return 85004756;
         4:  return 42667331;
         5:  return 21354465;
         6:  return 10679838;
         7:  return 5340245;
         8:  return 2670163;
         9:  return 1335087;
         10: return 667544;
         11: return 333772;
         12: return 166886;
         13: return 83443;
         14: return 41722;
         15: return 20861;
         16: return 10430;
         17: return 5215;
         18: return 2608;
         19: return 1304;
         20: return 652;
         21: return 326;
         22: return 163;
         23: return 81;
         default: return 0;
      endcase
   endfunction

   function automatic void outline_point(input int v, output int dx, output int dy);
      case (v % prst_pkg::OUTLINE_SIZE)
         1:       begin dx = 30;  dy = 0;   end
         2:       begin dx = 0;   dy = -30; end
         3:       begin dx = -30; dy = -30; end
         4:       begin dx = -30; dy = 30;  end
         5:       begin dx = 0;   dy = 30;  end
         6:       begin dx = 30;  dy = 0;   end
         default: begin dx = 0;   dy = 0;   end
      endcase
   endfunction

   // cos/sin in Q2.16, half turns folded into the right half-plane
   function automatic void cordic_cos_sin(input logic signed [prst_pkg::ANG_W-1:0] ang,
                                          output longint c, output longint s);
      longint x, y, z, nx;
      int     a;
      bit     flip;
      a = ang;
      flip = 1'b0;
      if (a > 16384) begin
         a -= 32768;
         flip = 1'b1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1'b1;
      end
      x = 39797;
      y = 0;
      z = longint'(a) * 65536;
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_turn(i);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_turn(i);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic void predict_outline(input logic signed [prst_pkg::POS_W-1:0] px,
                                           input logic signed [prst_pkg::POS_W-1:0] py);
      longint     c, s, p, q, rx, ry;
      int         dx, dy;
      vertex_type v;
      cordic_cos_sin(angle_now, c, s);
      for (int i = 0; i < prst_pkg::DEF_NUM_VERTICES; i++) begin
         outline_point(i, dx, dy);
         p  = longint'(dx) * longint'(scale_now);
         q  = longint'(dy) * longint'(scale_now);
         rx = p * c - q * s;
         ry = p * s + q * c;
         v.index = i[prst_pkg::IDX_OUT_W-1:0];
         v.gx    = prst_pkg::OUT_W'(((rx + (64'sd1 <<< 19)) >>> prst_pkg::FRAC_SHIFT)
                                    + longint'(px));
         v.gy    = prst_pkg::OUT_W'(((ry + (64'sd1 <<< 19)) >>> prst_pkg::FRAC_SHIFT)
                                    + longint'(py));
         v.last  = (i == prst_pkg::DEF_NUM_VERTICES - 1);
         vertices_due = {vertices_due, v};
      end
   endfunction

   // position driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (positions_pending.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(0, 10);
            req_ch.valid <= 1'b0;
         end else begin
            next_pos = positions_pending.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.pos_x <= next_pos.x;
            req_ch.pos_y <= next_pos.y;
         end
      end
   end

   // result back-pressure, with a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
         stall_left <= 0;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // register shadow, prediction and result check
   always @(posedge clock) begin
      if (reset) begin
         angle_now = prst_pkg::ANGLE_RESET;
         scale_now = prst_pkg::SCALE_RESET;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               prst_pkg::CSR_ROTATION_ANGLE: angle_now = csr_ch.data;
               prst_pkg::CSR_SCALE_FACTOR:   scale_now = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            predict_outline(req_ch.pos_x, req_ch.pos_y);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (vertices_due.size() == 0) begin
               flag_mismatch("item with nothing outstanding, vertex", rsp_ch.vertex_index, 0);
            end else begin
               got_vertex = vertices_due.pop_front();
               if (rsp_ch.vertex_index !== got_vertex.index)
                  flag_mismatch("vertex_index", rsp_ch.vertex_index, got_vertex.index);
               if (rsp_ch.global_x !== got_vertex.gx)
                  flag_mismatch("global_x", rsp_ch.global_x, got_vertex.gx);
               if (rsp_ch.global_y !== got_vertex.gy)
                  flag_mismatch("global_y", rsp_ch.global_y, got_vertex.gy);
               if (rsp_ch.last_vertex !== got_vertex.last)
                  flag_mismatch("last_vertex", rsp_ch.last_vertex, got_vertex.last);
            end
         end
      end
   end

   task automatic send_pos(input logic signed [prst_pkg::POS_W-1:0] x,
                           input logic signed [prst_pkg::POS_W-1:0] y);
      position_type p;
      p.x = x;
      p.y = y;
      positions_pending = {positions_pending, p};
   endtask

   function automatic logic [prst_pkg::POS_W-1:0] random_coord();
      case ($urandom_range(0, 15))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return prst_pkg::POS_W'($urandom);
      endcase
   endfunction

   task automatic send_random(input int n);
      for (int i = 0; i < n; i++)
         send_pos(random_coord(), random_coord());
   endtask

   task automatic drain();
      do @(negedge clock);
      while (positions_pending.size() != 0 || req_ch.valid || vertices_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [prst_pkg::CSR_IDX_W-1:0] idx,
                            input logic [prst_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_config(input logic signed [prst_pkg::ANG_W-1:0] ang,
                             input logic [prst_pkg::SCL_W-1:0] scl);
      drain();
      write_reg(prst_pkg::CSR_ROTATION_ANGLE, ang);
      write_reg(prst_pkg::CSR_SCALE_FACTOR, scl);
      @(negedge clock);
   endtask

   initial begin
      logic signed [prst_pkg::ANG_W-1:0] ang;
      logic [prst_pkg::SCL_W-1:0]        scl;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, position extremes
      send_pos(16'sh0000, 16'sh0000);
      send_pos(16'sh7FFF, 16'sh7FFF);
      send_pos(16'sh8000, 16'sh8000);
      send_pos(16'sh7FFF, 16'sh8000);
      send_pos(16'sh8000, 16'sh7FFF);
      send_pos(16'sh5555, 16'shAAAA);

      // quarter-turn fold boundaries and scale extremes
      set_config(16'sd16384, 16'hFFFF);
      send_pos(16'sh7FFF, 16'sh7FFF);
      send_pos(16'sh8000, 16'sh8000);
      set_config(16'sd16385, 16'hFFFF);
      send_pos(16'sh7FFF, 16'sh8000);
      set_config(-16'sd16384, 16'h0000);
      send_pos(16'sh0001, 16'shFFFF);
      set_config(-16'sd16385, 16'h0001);
      send_pos(16'shFFFF, 16'sh0001);
      set_config(16'sh8000, 16'hFFFF);
      send_pos(16'sh8000, 16'sh7FFF);
      send_pos(16'sh7FFF, 16'sh8000);
      set_config(16'sh7FFF, 16'd256);
      send_pos(16'sh0000, 16'sh0000);

      // unknown index must leave both registers alone
      set_config(16'sd8192, 16'd384);
      write_reg(CSR_UNUSED, 16'hFFFF);
      @(negedge clock);
      send_pos(16'sh1234, -16'sh1234);

      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 9))
            0:       ang = 16'sh8000;
            1:       ang = 16'sh7FFF;
            2:       ang = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16385;
            3:       ang = 16'sh0000;
            default: ang = prst_pkg::ANG_W'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0:       scl = 16'h0000;
            1:       scl = 16'hFFFF;
            2:       scl = prst_pkg::SCALE_RESET;
            default: scl = prst_pkg::SCL_W'($urandom);
         endcase
         set_config(ang, scl);
         if (ph == 2)
            hold_asked++;
         if (ph == 7)
            calm = 1'b1;
         send_random(50);
      end

      drain();
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatches == 0 && vertices_due.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
